// ----- hw/rtl/kdr_pkg.sv -----
package kdr_pkg;

    localparam int SOFT_TIMERS_DEF = 8;
    localparam int FLAG_W = 12;
    localparam int FLAG_DICE = 3;
    localparam int FLAG_TIMER0 = 4;
    localparam int FLAG_CHRONO0 = 10;
    localparam int GENERAL_FLAGS = 6;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_KEY = 2'd1;
    localparam logic [1:0] MODE_LOAD = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [2:0] REG_DEBOUNCE = 3'd0;
    localparam logic [2:0] REG_RDELAY = 3'd1;
    localparam logic [2:0] REG_RPERIOD = 3'd2;
    localparam logic [2:0] REG_BATTERY = 3'd3;
    localparam logic [2:0] REG_ALARM1 = 3'd4;
    localparam logic [2:0] REG_ALARM2 = 3'd5;

    typedef struct packed {
        logic [7:0]  debounce_ticks;
        logic [15:0] repeat_delay;
        logic [7:0]  repeat_period;
        logic [31:0] battery_period;
        logic [31:0] alarm1;
        logic [31:0] alarm2;
    } cfg_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic        zero_rem;
    } div_rsp_t;

endpackage

// ----- hw/rtl/kdr_divider.sv -----
module kdr_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  kdr_pkg::div_req_t   req,
    output kdr_pkg::div_rsp_t   rsp
);
    import kdr_pkg::*;

    logic [31:0] quot_reg, quot_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[31:0], quot_reg[31]} - {1'b0, dsr_reg};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next = '0;
            dsr_next = req.divisor;
            cnt_next = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial;
            end
            else
            begin
                rem_next = {rem_reg[31:0], quot_reg[31]};
            end
            quot_next = {quot_reg[30:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.zero_rem = (rem_reg == '0);

endmodule

// ----- hw/rtl/kdr_timer_mem.sv -----
module kdr_timer_mem #(
    parameter int DEPTH = kdr_pkg::SOFT_TIMERS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [31:0]              wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [31:0]              rdata
);
    import kdr_pkg::*;

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/key_debounce_repeat_and_soft_timers.sv -----
// Sequence: a key edge, load or clear is captured, applied and then offered as a result; a tick
// also walks the timer memory and, for each running chronograph with its alarm set, runs a
// 32-step modulo on the divider before its result is offered.
// Throughput: one item at a time; the next transfer is taken once the result has gone.
// Reset: all counters, flags, the timer valid bits and the configuration registers go to their defaults.
// Timer memory entries read as zero until written, through per-entry valid bits.
module key_debounce_repeat_and_soft_timers #(
    parameter int SOFT_TIMERS = kdr_pkg::SOFT_TIMERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata fields from bit 0: mode[2], key_group[2], keys_held[3], control_bits[3],
    // timer_index[3], load_value[32], clear_flags[12], clear_chronos[2], zero fill
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata fields from bit 0: event_flags[12], key_tone[1], battery_check[1],
    // tick_count[32], chrono1_snapshot[32], chrono2_snapshot[32], zero fill
    output logic [111:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import kdr_pkg::*;

    localparam int TW = $clog2(SOFT_TIMERS);
    localparam logic [TW-1:0] LAST_T = TW'(SOFT_TIMERS - 1);
    localparam logic [TW-1:0] DICE_T = TW'(SOFT_TIMERS - 2);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_KEYS = 3'd1;
    localparam logic [2:0] ST_WALK = 3'd2;
    localparam logic [2:0] ST_DIV = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_OUT = 3'd5;

    cfg_t cfg_reg;
    logic [2:0] state_reg;
    logic [63:0] item_reg;
    logic [7:0] deb_reg [3];
    logic [15:0] rst_cnt_reg [2];
    logic [7:0] rate_reg [2];
    logic [31:0] chr_reg [2];
    logic [31:0] snap_reg [2];
    logic [FLAG_W-1:0] flags_reg;
    logic [31:0] ticks_reg;
    logic tone_reg, batt_reg;
    logic [SOFT_TIMERS-1:0] tvalid_reg;
    logic [TW:0] walk_reg;
    logic ch_reg;
    logic chinc_reg;

    logic [1:0] i_mode, i_grp;
    logic [2:0] i_held, i_ctrl, i_tidx;
    logic [31:0] i_load;
    logic [11:0] i_clrf;
    logic [1:0] i_clrc;

    assign i_mode = item_reg[1:0];
    assign i_grp = item_reg[3:2];
    assign i_held = item_reg[6:4];
    assign i_ctrl = item_reg[9:7];
    assign i_tidx = item_reg[12:10];
    assign i_load = item_reg[44:13];
    assign i_clrf = item_reg[56:45];
    assign i_clrc = item_reg[58:57];

    logic mem_we;
    logic [TW-1:0] mem_waddr, mem_raddr, walk_idx, prev_idx;
    logic [31:0] mem_wdata, mem_rdata, tval;
    div_req_t dreq;
    div_rsp_t drsp;
    logic [31:0] alarm_sel, chr_inc;

    assign walk_idx = walk_reg[TW-1:0];
    assign prev_idx = TW'(walk_reg - 1'b1);
    assign mem_raddr = walk_idx;
    assign tval = tvalid_reg[prev_idx] ? mem_rdata : 32'd0;
    assign alarm_sel = ch_reg ? cfg_reg.alarm2 : cfg_reg.alarm1;
    assign chr_inc = chr_reg[ch_reg] + 32'd1;

    always_comb
    begin
        mem_we = 1'b0;
        mem_waddr = prev_idx;
        mem_wdata = tval - 32'd1;
        if (state_reg == ST_KEYS && i_mode == MODE_LOAD
            && {29'd0, i_tidx} < 32'(SOFT_TIMERS))
        begin
            mem_we = 1'b1;
            mem_waddr = TW'(i_tidx);
            mem_wdata = i_load;
        end
        else if (state_reg == ST_WALK && walk_reg != '0 && tval != 32'd0)
        begin
            mem_we = 1'b1;
            if (prev_idx == LAST_T && tval == 32'd1)
            begin
                mem_wdata = cfg_reg.battery_period;
            end
        end
    end

    kdr_timer_mem #(.DEPTH(SOFT_TIMERS)) u_mem (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    assign dreq.start = (state_reg == ST_DIV) && chinc_reg && (alarm_sel != 32'd0);
    assign dreq.dividend = chr_reg[ch_reg];
    assign dreq.divisor = alarm_sel;

    kdr_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata = {2'b00, snap_reg[1], snap_reg[0], ticks_reg, batt_reg, tone_reg,
                           flags_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{8'd20, 16'd500, 8'd100, 32'd60000, 32'd0, 32'd0};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE: cfg_reg.debounce_ticks <= cfg_data[7:0];
                REG_RDELAY: cfg_reg.repeat_delay <= cfg_data[15:0];
                REG_RPERIOD: cfg_reg.repeat_period <= cfg_data[7:0];
                REG_BATTERY: cfg_reg.battery_period <= cfg_data;
                REG_ALARM1: cfg_reg.alarm1 <= cfg_data;
                REG_ALARM2: cfg_reg.alarm2 <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg <= s_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        logic [FLAG_W-1:0] f;
        logic t;
        logic [7:0] d;
        logic [15:0] rs;
        logic [7:0] rr;
        logic h;
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int g = 0; g < 3; g++)
            begin
                deb_reg[g] <= '0;
            end
            for (int g = 0; g < 2; g++)
            begin
                rst_cnt_reg[g] <= '0;
                rate_reg[g] <= '0;
                chr_reg[g] <= '0;
                snap_reg[g] <= '0;
            end
            flags_reg <= '0;
            ticks_reg <= '0;
            tone_reg <= 1'b0;
            batt_reg <= 1'b0;
            tvalid_reg <= '0;
            walk_reg <= '0;
            ch_reg <= 1'b0;
            chinc_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        state_reg <= ST_KEYS;
                    end
                end
                ST_KEYS:
                begin
                    batt_reg <= 1'b0;
                    walk_reg <= '0;
                    if (i_mode != MODE_TICK)
                    begin
                        tone_reg <= 1'b0;
                        state_reg <= ST_OUT;
                    end
                    case (i_mode)
                        MODE_TICK:
                        begin
                            f = flags_reg;
                            t = 1'b0;
                            for (int g = 0; g < 3; g++)
                            begin
                                h = i_held[g];
                                d = deb_reg[g];
                                if (d != 8'd0)
                                begin
                                    d = d - 8'd1;
                                    if (d == 8'd0)
                                    begin
                                        f[g] = 1'b1;
                                        if (h)
                                        begin
                                            t = 1'b1;
                                        end
                                    end
                                end
                                deb_reg[g] <= d;
                                if (g < 2)
                                begin
                                    rs = rst_cnt_reg[g];
                                    rr = rate_reg[g];
                                    if (deb_reg[g] == 8'd1 && h && i_ctrl[0])
                                    begin
                                        rs = cfg_reg.repeat_delay;
                                    end
                                    if (rs != 16'd0)
                                    begin
                                        rs = rs - 16'd1;
                                        if (rs == 16'd0 && h)
                                        begin
                                            rr = cfg_reg.repeat_period;
                                        end
                                    end
                                    if (rr != 8'd0)
                                    begin
                                        rr = rr - 8'd1;
                                        if (rr == 8'd0 && h)
                                        begin
                                            rr = cfg_reg.repeat_period;
                                            f[g] = 1'b1;
                                        end
                                    end
                                    rst_cnt_reg[g] <= rs;
                                    rate_reg[g] <= rr;
                                end
                            end
                            flags_reg <= f;
                            tone_reg <= t;
                            ticks_reg <= ticks_reg + 32'd1;
                            state_reg <= ST_WALK;
                        end
                        MODE_KEY:
                        begin
                            if (i_grp != 2'd3)
                            begin
                                deb_reg[i_grp] <= cfg_reg.debounce_ticks;
                            end
                        end
                        MODE_LOAD:
                        begin
                            if ({29'd0, i_tidx} < 32'(SOFT_TIMERS))
                            begin
                                tvalid_reg[TW'(i_tidx)] <= 1'b1;
                            end
                        end
                        default:
                        begin
                            flags_reg <= flags_reg & ~i_clrf;
                            for (int c = 0; c < 2; c++)
                            begin
                                if (i_clrc[c])
                                begin
                                    chr_reg[c] <= '0;
                                    snap_reg[c] <= '0;
                                end
                            end
                        end
                    endcase
                end
                ST_WALK:
                begin
                    walk_reg <= walk_reg + 1'b1;
                    if (walk_reg != '0)
                    begin
                        if (tval != 32'd0)
                        begin
                            tvalid_reg[prev_idx] <= 1'b1;
                        end
                        if (tval == 32'd1)
                        begin
                            if (prev_idx == LAST_T)
                            begin
                                batt_reg <= 1'b1;
                            end
                            else if (prev_idx == DICE_T)
                            begin
                                flags_reg[FLAG_DICE] <= 1'b1;
                            end
                            else if (32'(prev_idx) < GENERAL_FLAGS)
                            begin
                                flags_reg[FLAG_TIMER0 + 32'(prev_idx)] <= 1'b1;
                            end
                        end
                        if (prev_idx == LAST_T)
                        begin
                            ch_reg <= 1'b0;
                            chinc_reg <= 1'b0;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (!chinc_reg)
                    begin
                        if (i_ctrl[{1'b0, ch_reg} + 2'd1])
                        begin
                            chr_reg[ch_reg] <= chr_inc;
                            chinc_reg <= 1'b1;
                        end
                        else if (ch_reg)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            ch_reg <= 1'b1;
                        end
                    end
                    else if (alarm_sel != 32'd0)
                    begin
                        state_reg <= ST_WAIT;
                    end
                    else
                    begin
                        chinc_reg <= 1'b0;
                        if (ch_reg)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            ch_reg <= 1'b1;
                        end
                    end
                end
                ST_WAIT:
                begin
                    if (drsp.done)
                    begin
                        if (drsp.zero_rem)
                        begin
                            snap_reg[ch_reg] <= chr_reg[ch_reg];
                            flags_reg[FLAG_CHRONO0 + 32'(ch_reg)] <= 1'b1;
                        end
                        chinc_reg <= 1'b0;
                        if (ch_reg)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            ch_reg <= 1'b1;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("input and output open together");
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_flags_only_nontick: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && item_reg[1:0] != MODE_TICK |-> !m_axis_tdata[12] && !m_axis_tdata[13])
        else $error("tone or battery pulse on a non-tick item");

endmodule

// ----- sim/tb_key_debounce_repeat_and_soft_timers.sv -----
module tb_key_debounce_repeat_and_soft_timers;
    timeunit 1ns;
    timeprecision 1ps;

    import kdr_pkg::*;

    localparam int NTIMERS = SOFT_TIMERS_DEF;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]  clear_chronos;
        logic [11:0] clear_flags;
        logic [31:0] load_value;
        logic [2:0]  timer_index;
        logic [2:0]  control_bits;
        logic [2:0]  keys_held;
        logic [1:0]  key_group;
        logic [1:0]  mode;
    } op_t;

    typedef struct packed {
        logic [31:0] snap2;
        logic [31:0] snap1;
        logic [31:0] tick_count;
        logic        battery_check;
        logic        key_tone;
        logic [11:0] event_flags;
    } status_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    key_debounce_repeat_and_soft_timers dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Shadow copy of the block's registers and counters.
    logic [7:0]  debounce_reload;
    logic [15:0] delay_reload;
    logic [7:0]  period_reload;
    logic [31:0] battery_reload;
    logic [31:0] alarm_period [2];
    logic [7:0]  key_mask_cnt [3];
    logic [15:0] hold_cnt [2];
    logic [7:0]  rate_cnt [2];
    logic [31:0] timer_cnt [NTIMERS];
    logic [31:0] chrono_cnt [2];
    logic [31:0] chrono_snap [2];
    logic [11:0] flags;
    logic [31:0] ticks;

    op_t     pending_ops [$];
    status_t expected_status [$];
    int      mismatches;
    int      cycles;
    bit      idle_free;
    bit      sender_pause;
    int      hold_off;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic bit key_settle(int g, bit held);
        if (key_mask_cnt[g] != 0)
        begin
            key_mask_cnt[g] = key_mask_cnt[g] - 8'd1;
            if (key_mask_cnt[g] == 0)
            begin
                flags[g] = 1'b1;
                return held;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit player_step(int g, logic [2:0] held, bit rep);
        bit h;
        bit tone;
        h = held[g];
        tone = key_settle(g, h);
        if (tone && rep)
            hold_cnt[g] = delay_reload;
        if (hold_cnt[g] != 0)
        begin
            hold_cnt[g] = hold_cnt[g] - 16'd1;
            if (hold_cnt[g] == 0 && h)
                rate_cnt[g] = period_reload;
        end
        if (rate_cnt[g] != 0)
        begin
            rate_cnt[g] = rate_cnt[g] - 8'd1;
            if (rate_cnt[g] == 0 && h)
            begin
                rate_cnt[g] = period_reload;
                flags[g] = 1'b1;
            end
        end
        return tone;
    endfunction

    function automatic status_t apply_op(op_t op);
        status_t r;
        bit tone;
        bit batt;
        tone = 1'b0;
        batt = 1'b0;
        case (op.mode)
            MODE_TICK:
            begin
                if (player_step(0, op.keys_held, op.control_bits[0])) tone = 1'b1;
                if (player_step(1, op.keys_held, op.control_bits[0])) tone = 1'b1;
                if (key_settle(2, op.keys_held[2])) tone = 1'b1;
                for (int i = 0; i < NTIMERS - 1; i++)
                begin
                    if (timer_cnt[i] != 0)
                    begin
                        timer_cnt[i] = timer_cnt[i] - 32'd1;
                        if (timer_cnt[i] == 0)
                        begin
                            if (i == NTIMERS - 2)
                                flags[FLAG_DICE] = 1'b1;
                            else if (i < GENERAL_FLAGS)
                                flags[FLAG_TIMER0 + i] = 1'b1;
                        end
                    end
                end
                if (timer_cnt[NTIMERS - 1] != 0)
                begin
                    timer_cnt[NTIMERS - 1] = timer_cnt[NTIMERS - 1] - 32'd1;
                    if (timer_cnt[NTIMERS - 1] == 0)
                    begin
                        timer_cnt[NTIMERS - 1] = battery_reload;
                        batt = 1'b1;
                    end
                end
                for (int i = 0; i < 2; i++)
                begin
                    if (op.control_bits[i + 1])
                    begin
                        chrono_cnt[i] = chrono_cnt[i] + 32'd1;
                        if (alarm_period[i] != 0 && chrono_cnt[i] % alarm_period[i] == 0)
                        begin
                            chrono_snap[i] = chrono_cnt[i];
                            flags[FLAG_CHRONO0 + i] = 1'b1;
                        end
                    end
                end
                ticks = ticks + 32'd1;
            end
            MODE_KEY:
            begin
                if (op.key_group < 3)
                    key_mask_cnt[op.key_group] = debounce_reload;
            end
            MODE_LOAD:
            begin
                if (op.timer_index < NTIMERS)
                    timer_cnt[op.timer_index] = op.load_value;
            end
            default:
            begin
                flags = flags & ~op.clear_flags;
                for (int i = 0; i < 2; i++)
                begin
                    if (op.clear_chronos[i])
                    begin
                        chrono_cnt[i] = '0;
                        chrono_snap[i] = '0;
                    end
                end
            end
        endcase
        r.event_flags = flags;
        r.key_tone = tone;
        r.battery_check = batt;
        r.tick_count = ticks;
        r.snap1 = chrono_snap[0];
        r.snap2 = chrono_snap[1];
        return r;
    endfunction

    function automatic logic [63:0] pack_op(op_t op);
        return {5'b0, op};
    endfunction

    function automatic op_t tick_op(logic [2:0] held, logic [2:0] ctrl);
        op_t op;
        op = '0;
        op.mode = MODE_TICK;
        op.keys_held = held;
        op.control_bits = ctrl;
        return op;
    endfunction

    function automatic op_t random_op();
        op_t op;
        op.mode = 2'($urandom_range(0, 3));
        op.key_group = 2'($urandom_range(0, 3));
        op.keys_held = 3'($urandom_range(0, 7));
        op.control_bits = 3'($urandom_range(0, 7));
        op.timer_index = 3'($urandom_range(0, 7));
        op.load_value = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 40);
        op.clear_flags = 12'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : 0);
        op.clear_chronos = 2'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : 0);
        if (op.mode == MODE_TICK && $urandom_range(0, 1) == 1)
            op.keys_held = 3'b111;
        return op;
    endfunction

    // Driver: the model is advanced at each input transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_status.push_back(apply_op(s_axis_tdata[58:0]));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_ops.size() > 0 && !sender_pause
                    && (idle_free || $urandom_range(0, 99) >= 8))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pack_op(pending_ops.pop_front());
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= idle_free || $urandom_range(0, 99) >= 8;
    end

    always @(posedge clk)
    begin
        status_t got;
        status_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[109:0];
            if (expected_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected status transfer %h", m_axis_tdata);
            end
            else
            begin
                want = expected_status.pop_front();
                if (got.event_flags !== want.event_flags || got.key_tone !== want.key_tone
                    || got.battery_check !== want.battery_check
                    || got.tick_count !== want.tick_count
                    || got.snap1 !== want.snap1 || got.snap2 !== want.snap2)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: flags %h/%h tone %b/%b batt %b/%b ticks %h/%h",
                                  " snap %h %h/%h %h"},
                                 want.event_flags, got.event_flags, want.key_tone, got.key_tone,
                                 want.battery_check, got.battery_check, want.tick_count,
                                 got.tick_count, want.snap1, want.snap2, got.snap1, got.snap2);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_ops.size() > 0 || s_axis_tvalid || expected_status.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_DEBOUNCE: debounce_reload = value[7:0];
            REG_RDELAY: delay_reload = value[15:0];
            REG_RPERIOD: period_reload = value[7:0];
            REG_BATTERY: battery_reload = value;
            REG_ALARM1: alarm_period[0] = value;
            default: alarm_period[1] = value;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // A press sequence: key edge, then nticks ticks, with the keys held on most of them.
    task automatic queue_press(int g, int nticks, bit rep);
        op_t op;
        op = '0;
        op.mode = MODE_KEY;
        op.key_group = 2'(g);
        pending_ops.push_back(op);
        for (int i = 0; i < nticks; i++)
            pending_ops.push_back(tick_op($urandom_range(0, 9) == 0 ? 3'b000 : 3'b111,
                                          {2'($urandom_range(0, 3)), rep}));
    endtask

    initial
    begin
        op_t op;
        int total;
        mismatches = 0;
        cycles = 0;
        idle_free = 1'b0;
        sender_pause = 1'b0;
        hold_off = 0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        debounce_reload = 8'd20;
        delay_reload = 16'd500;
        period_reload = 8'd100;
        battery_reload = 32'd60000;
        alarm_period[0] = '0;
        alarm_period[1] = '0;
        for (int i = 0; i < 3; i++) key_mask_cnt[i] = '0;
        for (int i = 0; i < 2; i++)
        begin
            hold_cnt[i] = '0;
            rate_cnt[i] = '0;
            chrono_cnt[i] = '0;
            chrono_snap[i] = '0;
        end
        for (int i = 0; i < NTIMERS; i++) timer_cnt[i] = '0;
        flags = '0;
        ticks = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, mostly with short reloads so most actions show up quickly.
        write_reg(REG_DEBOUNCE, 32'd2);
        write_reg(REG_RDELAY, 32'd3);
        write_reg(REG_RPERIOD, 32'd2);
        write_reg(REG_BATTERY, 32'd3);
        write_reg(REG_ALARM1, 32'd2);
        write_reg(REG_ALARM2, 32'hFFFF_FFFF);
        for (int g = 0; g < 4; g++)
        begin
            op = '0;
            op.mode = MODE_KEY;
            op.key_group = 2'(g);
            pending_ops.push_back(op);
        end
        for (int t = 0; t < 8; t++)
        begin
            op = '0;
            op.mode = MODE_LOAD;
            op.timer_index = 3'(t);
            op.load_value = (t == 5) ? 32'hFFFF_FFFF : 32'(t % 3 + 1);
            pending_ops.push_back(op);
        end
        for (int i = 0; i < 8; i++)
            pending_ops.push_back(tick_op(3'b111, 3'b111));
        op = '0;
        op.mode = MODE_LOAD;
        op.timer_index = 3'd5;
        pending_ops.push_back(op);
        op = '0;
        op.mode = MODE_CLEAR;
        op.clear_flags = 12'hFFF;
        op.clear_chronos = 2'b11;
        pending_ops.push_back(op);
        pending_ops.push_back(tick_op(3'b000, 3'b000));
        wait_drained();

        // Zero reloads stop the follow-up counters.
        write_reg(REG_DEBOUNCE, 32'd0);
        write_reg(REG_RDELAY, 32'd0);
        write_reg(REG_RPERIOD, 32'd0);
        write_reg(REG_BATTERY, 32'd0);
        write_reg(REG_ALARM1, 32'd0);
        write_reg(REG_ALARM2, 32'd1);
        queue_press(0, 4, 1'b1);
        op = '0;
        op.mode = MODE_LOAD;
        op.timer_index = 3'd7;
        op.load_value = 32'd1;
        pending_ops.push_back(op);
        for (int i = 0; i < 3; i++)
            pending_ops.push_back(tick_op(3'b111, 3'b110));
        wait_drained();

        // Receiver holds off while the sender keeps offering.
        hold_off = 400;
        for (int i = 0; i < 30; i++)
            pending_ops.push_back(random_op());
        wait_drained();

        total = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(REG_DEBOUNCE, $urandom_range(0, 4) == 0 ? 32'd255 : $urandom_range(1, 5));
            write_reg(REG_RDELAY, $urandom_range(0, 4) == 0 ? 32'd65535 : $urandom_range(1, 8));
            write_reg(REG_RPERIOD, $urandom_range(1, 4));
            write_reg(REG_BATTERY, phase == 3 ? 32'hFFFF_FFFF : $urandom_range(1, 10));
            write_reg(REG_ALARM1, $urandom_range(1, 6));
            write_reg(REG_ALARM2, phase == 2 ? 32'hFFFF_FFFF : $urandom_range(0, 9));
            idle_free = (phase == 1);
            while (total < 320 * (phase + 1))
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    op = random_op();
                    pending_ops.push_back(op);
                    total++;
                end
                else
                begin
                    queue_press($urandom_range(0, 2), $urandom_range(3, 15),
                                $urandom_range(0, 3) != 0);
                    total += 10;
                end
            end
            wait_drained();
            sender_pause = 1'b1;
            repeat (20) @(posedge clk);
            sender_pause = 1'b0;
        end
        idle_free = 1'b0;
        wait_drained();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
